FILE: rtl/core/kst_pkg.sv
package kst_pkg;

    // Opcodes carried on the input tuser. The unused code does nothing and reports failure.
    localparam logic [2:0] OP_INSERT      = 3'd0;
    localparam logic [2:0] OP_REMOVE_KEY  = 3'd1;
    localparam logic [2:0] OP_REMOVE_RANK = 3'd2;
    localparam logic [2:0] OP_FIND_KEY    = 3'd3;
    localparam logic [2:0] OP_FIND_RANK   = 3'd4;
    localparam logic [2:0] OP_DRAW        = 3'd5;
    localparam logic [2:0] OP_SORT        = 3'd6;
    localparam logic [2:0] OP_UNUSED      = 3'd7;

    // One stored entry of the set: suit in the upper bits, rank in the lower bits.
    typedef struct packed {
        logic [2:0] suit;
        logic [3:0] rank;
    } t_entry;

    // Sort order: rank is the major field and suit the minor field.
    function automatic logic [6:0] sort_order(input t_entry e);
        return {e.rank, e.suit};
    endfunction

endpackage

FILE: rtl/core/keyed_set_table_engine.sv
// One item is worked on at a time: the next input beat can be taken in the cycle after the
// result is loaded, and the result is loaded only once the sink has taken any earlier result.
// Reset clears the entry count, the sequencer and the output valid; the store is not cleared.
module keyed_set_table_engine import kst_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0 up: key_suit[2:0], key_rank[6:3], position[12:7], zero fill.
    input  logic [15:0] i_s_tdata,
    // Fields from bit 0 up: opcode[2:0].
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0 up: ok[0], found_index[6:1], out_suit[9:7], out_rank[13:10],
    // entry_count[20:14], zero fill.
    output logic [23:0] o_m_tdata
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);
    localparam logic [CW-1:0] TWO = CW'(2);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DISP     = 9'b000000010,
        S_SCAN     = 9'b000000100,
        S_DRAW     = 9'b000001000,
        S_SHIFT    = 9'b000010000,
        S_SORT_LDW = 9'b000100000,
        S_SORT_CMP = 9'b001000000,
        S_SORT_PUT = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    logic [2:0]    r_op;
    logic [2:0]    r_suit;
    logic [3:0]    r_rank;
    logic [5:0]    r_pos;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_wa, n_wa;
    logic          r_pend, n_pend;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    t_entry        r_v, n_v;
    logic          r_res_ok, n_res_ok;
    logic [5:0]    r_res_idx, n_res_idx;
    logic [2:0]    r_res_suit, n_res_suit;
    logic [3:0]    r_res_rank, n_res_rank;
    logic          r_ovld, n_ovld;
    logic [20:0]   r_obeat, n_obeat;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    logic [IW-1:0] rd_addr;
    t_entry        rd_data;

    t_entry        key;
    logic          by_rank;
    logic          issue;
    logic          match;
    logic [CW-1:0] hit_pos;
    logic [CW-1:0] i_next;
    logic          load_out;

    kst_ram #(
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {3'b000, r_obeat};

    // Helpers for the scan, shift and sort steps and for the output register.
    assign key      = '{suit: r_suit, rank: r_rank};
    assign by_rank  = (r_op == OP_REMOVE_RANK) || (r_op == OP_FIND_RANK);
    assign issue    = (r_ptr < r_count);
    assign hit_pos  = r_ptr - ONE;
    assign match    = r_pend && (by_rank ? (rd_data.rank == r_rank) : (rd_data == key));
    assign i_next   = r_i + ONE;
    assign load_out = (r_state == S_DONE) && (!r_ovld || i_m_tready);

    // Sequencer: read, compare and write back through the store's one read port and one write port.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_wa       = r_wa;
        n_pend     = r_pend;
        n_i        = r_i;
        n_j        = r_j;
        n_v        = r_v;
        n_res_ok   = r_res_ok;
        n_res_idx  = r_res_idx;
        n_res_suit = r_res_suit;
        n_res_rank = r_res_rank;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = r_v;
        rd_addr    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                n_res_ok   = 1'b0;
                n_res_idx  = '0;
                n_res_suit = '0;
                n_res_rank = '0;
                n_ptr      = '0;
                n_pend     = 1'b0;
                case (r_op)
                    OP_INSERT, OP_REMOVE_KEY, OP_REMOVE_RANK, OP_FIND_KEY, OP_FIND_RANK: begin
                        n_state = S_SCAN;
                    end
                    OP_DRAW: begin
                        if (PW'(r_pos) < PW'(r_count)) begin
                            rd_addr = IW'(r_pos);
                            n_state = S_DRAW;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_SORT: begin
                        n_res_ok = 1'b1;
                        if (r_count > ONE) begin
                            rd_addr = IW'(ONE);
                            n_i     = ONE;
                            n_state = S_SORT_LDW;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Linear search: one read issued per cycle, its data compared in the following cycle.
            S_SCAN: begin
                rd_addr = IW'(r_ptr);
                if (match) begin
                    case (r_op)
                        OP_REMOVE_KEY, OP_REMOVE_RANK: begin
                            n_wa    = hit_pos;
                            n_pend  = 1'b0;
                            n_state = S_SHIFT;
                        end
                        OP_FIND_KEY, OP_FIND_RANK: begin
                            n_res_ok  = 1'b1;
                            n_res_idx = 6'(hit_pos);
                            n_state   = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end else if (!issue) begin
                    if ((r_op == OP_INSERT) && (r_count < CAP)) begin
                        wr_en    = 1'b1;
                        wr_addr  = IW'(r_count);
                        wr_data  = key;
                        n_count  = r_count + ONE;
                        n_res_ok = 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_ptr  = r_ptr + ONE;
                    n_pend = 1'b1;
                end
            end

            // The drawn entry arrives; then close the gap behind it.
            S_DRAW: begin
                n_res_suit = rd_data.suit;
                n_res_rank = rd_data.rank;
                n_wa       = CW'(r_pos);
                n_ptr      = CW'(r_pos) + ONE;
                n_pend     = 1'b0;
                n_state    = S_SHIFT;
            end

            // Move every later entry down one place: read ahead, write one behind.
            S_SHIFT: begin
                rd_addr = IW'(r_ptr);
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = IW'(r_wa);
                    wr_data = rd_data;
                    n_wa    = r_wa + ONE;
                end
                if (issue) begin
                    n_ptr  = r_ptr + ONE;
                    n_pend = 1'b1;
                end else begin
                    n_count  = r_count - ONE;
                    n_res_ok = 1'b1;
                    n_state  = S_DONE;
                end
            end

            // Insertion sort: take entry i and ask for its left neighbor.
            S_SORT_LDW: begin
                n_v     = rd_data;
                n_j     = r_i;
                rd_addr = IW'(r_i - ONE);
                n_state = S_SORT_CMP;
            end

            S_SORT_CMP: begin
                wr_en   = 1'b1;
                wr_addr = IW'(r_j);
                if (sort_order(rd_data) > sort_order(r_v)) begin
                    wr_data = rd_data;
                    n_j     = r_j - ONE;
                    if (r_j == ONE) begin
                        n_state = S_SORT_PUT;
                    end else begin
                        rd_addr = IW'(r_j - TWO);
                    end
                end else begin
                    wr_data = r_v;
                    if (i_next >= r_count) begin
                        n_state = S_DONE;
                    end else begin
                        n_i     = i_next;
                        rd_addr = IW'(i_next);
                        n_state = S_SORT_LDW;
                    end
                end
            end

            // The held entry belongs at the front.
            S_SORT_PUT: begin
                wr_en   = 1'b1;
                wr_addr = IW'(r_j);
                wr_data = r_v;
                if (i_next >= r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = i_next;
                    rd_addr = IW'(i_next);
                    n_state = S_SORT_LDW;
                end
            end

            S_DONE: begin
                if (!r_ovld || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: holds one result beat until the sink takes it.
    always_comb begin
        n_ovld  = r_ovld;
        n_obeat = r_obeat;
        if (load_out) begin
            n_ovld  = 1'b1;
            n_obeat = {7'(r_count), r_res_rank, r_res_suit, r_res_idx, r_res_ok};
        end else if (i_m_tready) begin
            n_ovld = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovld  <= n_ovld;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_s_tvalid) begin
            r_op   <= i_s_tuser;
            r_suit <= i_s_tdata[2:0];
            r_rank <= i_s_tdata[6:3];
            r_pos  <= i_s_tdata[12:7];
        end
        r_ptr      <= n_ptr;
        r_wa       <= n_wa;
        r_pend     <= n_pend;
        r_i        <= n_i;
        r_j        <= n_j;
        r_v        <= n_v;
        r_res_ok   <= n_res_ok;
        r_res_idx  <= n_res_idx;
        r_res_suit <= n_res_suit;
        r_res_rank <= n_res_rank;
        r_obeat    <= n_obeat;
    end

endmodule

FILE: rtl/core/kst_ram.sv
module kst_ram import kst_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  t_entry                   i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output t_entry                   o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sim/tb_keyed_set_table_engine.sv
`timescale 1ns / 1ps

module tb_keyed_set_table_engine;
    import kst_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int DRAIN_CYCLES = 20;

    // One result beat, unpacked.
    typedef struct packed {
        logic       ok;
        logic [5:0] index;
        logic [2:0] suit;
        logic [3:0] rank;
        logic [6:0] count;
    } t_set_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;
    logic [2:0]  i_s_tuser  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;

    // Predicted contents of the set, kept densely in insertion order until a sort reorders them.
    t_entry      set_store [CAPACITY];
    int          set_count = 0;

    t_set_result pending_results [$];
    int          error_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          hold_request   = 0;
    int          hold_left      = 0;

    keyed_set_table_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Overall time limit for the run.
    initial begin
        #20_000_000;
        $display("FAIL keyed_set_table_engine");
        $finish;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_error(input string msg);
        error_count++;
        $display("[%0t] %s", $time, msg);
    endtask

    // Returns the first position that matches the key (or only its rank), else the count.
    function automatic int locate_entry(input t_entry want, input bit by_rank);
        for (int i = 0; i < set_count; i++) begin
            if (by_rank ? (set_store[i].rank == want.rank) : (set_store[i] == want)) begin
                return i;
            end
        end
        return set_count;
    endfunction

    // Deletes one entry and shifts every later entry down by one place.
    function automatic void remove_entry(input int pos);
        set_count--;
        for (int i = pos; i < set_count; i++) begin
            set_store[i] = set_store[i + 1];
        end
    endfunction

    // Applies one operation to the predicted set and returns the expected result beat.
    function automatic t_set_result apply_set_op(input logic [2:0] op, input logic [2:0] suit,
                                                 input logic [3:0] rank,
                                                 input logic [5:0] pos);
        t_set_result res;
        t_entry      key;
        t_entry      moving;
        int          hit;
        int          j;
        res      = '0;
        key.suit = suit;
        key.rank = rank;
        case (op)
            OP_INSERT: begin
                if (locate_entry(key, 1'b0) == set_count && set_count < CAPACITY) begin
                    set_store[set_count] = key;
                    set_count++;
                    res.ok = 1'b1;
                end
            end
            OP_REMOVE_KEY, OP_REMOVE_RANK: begin
                hit = locate_entry(key, op == OP_REMOVE_RANK);
                if (hit < set_count) begin
                    remove_entry(hit);
                    res.ok = 1'b1;
                end
            end
            OP_FIND_KEY, OP_FIND_RANK: begin
                hit = locate_entry(key, op == OP_FIND_RANK);
                if (hit < set_count) begin
                    res.ok    = 1'b1;
                    res.index = hit[5:0];
                end
            end
            OP_DRAW: begin
                if (int'(pos) < set_count) begin
                    res.suit = set_store[pos].suit;
                    res.rank = set_store[pos].rank;
                    remove_entry(int'(pos));
                    res.ok = 1'b1;
                end
            end
            OP_SORT: begin
                // Insertion sort, rank first and suit second.
                for (int i = 1; i < set_count; i++) begin
                    moving = set_store[i];
                    j = i;
                    while (j > 0 && {set_store[j - 1].rank, set_store[j - 1].suit} >
                                    {moving.rank, moving.suit}) begin
                        set_store[j] = set_store[j - 1];
                        j--;
                    end
                    set_store[j] = moving;
                end
                res.ok = 1'b1;
            end
            default: begin
            end
        endcase
        res.count = set_count[6:0];
        return res;
    endfunction

    // Offers one input beat, waits for it to be taken, then records the expected result.
    task automatic send_item(input logic [2:0] op, input logic [2:0] suit,
                             input logic [3:0] rank, input logic [5:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, pos, rank, suit};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(apply_set_op(op, suit, rank, pos));
    endtask

    // Stops sending and waits until every expected result beat has come back.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Picks one random operation; keys and positions often hit entries that are held.
    task automatic send_random_item(input int target_count);
        logic [2:0] op;
        logic [2:0] suit;
        logic [3:0] rank;
        logic [5:0] pos;
        int         pick;
        int         insert_pct;
        suit = 3'($urandom_range(7));
        rank = 4'($urandom_range(15));
        pos  = 6'($urandom_range(63));
        if (set_count > 0 && $urandom_range(1) == 0) begin
            pick = $urandom_range(set_count - 1);
            suit = set_store[pick].suit;
            rank = set_store[pick].rank;
        end
        if (set_count > 0 && $urandom_range(2) != 0) begin
            pos = 6'($urandom_range(set_count - 1));
        end
        insert_pct = (set_count < target_count) ? 60 : 10;
        pick = $urandom_range(99);
        if ($urandom_range(99) < insert_pct) begin
            op = OP_INSERT;
        end else if (pick < 20) begin
            op = OP_REMOVE_KEY;
        end else if (pick < 35) begin
            op = OP_REMOVE_RANK;
        end else if (pick < 55) begin
            op = OP_FIND_KEY;
        end else if (pick < 70) begin
            op = OP_FIND_RANK;
        end else if (pick < 94) begin
            op = OP_DRAW;
        end else if (pick < 97) begin
            op = OP_SORT;
        end else begin
            op = OP_UNUSED;
        end
        send_item(op, suit, rank, pos);
    endtask

    // Receiver side: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compares each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_set_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("result beat with no expectation: %h", o_m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[0] !== want.ok) begin
                    report_error($sformatf("ok: got %b, expected %b", o_m_tdata[0], want.ok));
                end
                if (o_m_tdata[6:1] !== want.index) begin
                    report_error($sformatf("found_index: got %0d, expected %0d",
                                           o_m_tdata[6:1], want.index));
                end
                if (o_m_tdata[9:7] !== want.suit) begin
                    report_error($sformatf("out_suit: got %0d, expected %0d",
                                           o_m_tdata[9:7], want.suit));
                end
                if (o_m_tdata[13:10] !== want.rank) begin
                    report_error($sformatf("out_rank: got %0d, expected %0d",
                                           o_m_tdata[13:10], want.rank));
                end
                if (o_m_tdata[20:14] !== want.count) begin
                    report_error($sformatf("entry_count: got %0d, expected %0d",
                                           o_m_tdata[20:14], want.count));
                end
            end
        end
    end

    // Empty-set cases, duplicates, first-match searches, draws past the count, small sorts.
    task automatic test_directed();
        send_item(OP_SORT,        3'd0, 4'd0,  6'd0);
        send_item(OP_DRAW,        3'd0, 4'd0,  6'd0);
        send_item(OP_REMOVE_KEY,  3'd0, 4'd0,  6'd0);
        send_item(OP_REMOVE_RANK, 3'd0, 4'd0,  6'd0);
        send_item(OP_FIND_KEY,    3'd7, 4'd15, 6'd0);
        send_item(OP_FIND_RANK,   3'd7, 4'd15, 6'd0);
        send_item(OP_UNUSED,      3'd0, 4'd0,  6'd0);
        send_item(OP_INSERT,      3'd7, 4'd15, 6'd0);
        send_item(OP_INSERT,      3'd7, 4'd15, 6'd0);
        send_item(OP_SORT,        3'd0, 4'd0,  6'd0);
        send_item(OP_INSERT,      3'd0, 4'd0,  6'd63);
        send_item(OP_INSERT,      3'd3, 4'd0,  6'd0);
        send_item(OP_INSERT,      3'd5, 4'd9,  6'd0);
        send_item(OP_FIND_KEY,    3'd3, 4'd0,  6'd0);
        send_item(OP_FIND_RANK,   3'd6, 4'd0,  6'd0);
        send_item(OP_FIND_RANK,   3'd0, 4'd15, 6'd0);
        send_item(OP_REMOVE_RANK, 3'd1, 4'd0,  6'd0);
        send_item(OP_REMOVE_KEY,  3'd5, 4'd9,  6'd0);
        send_item(OP_DRAW,        3'd0, 4'd0,  6'd2);
        send_item(OP_DRAW,        3'd7, 4'd15, 6'd63);
        send_item(OP_INSERT,      3'd0, 4'd15, 6'd0);
        send_item(OP_SORT,        3'd0, 4'd0,  6'd0);
        send_item(OP_FIND_KEY,    3'd0, 4'd15, 6'd0);
        send_item(OP_DRAW,        3'd0, 4'd0,  6'd1);
        send_item(OP_UNUSED,      3'd7, 4'd15, 6'd63);
    endtask

    // Fills the set to capacity, inserts into a full set, sorts, and empties it again;
    // the second fill goes in reverse sort order so that the sort moves every entry.
    task automatic test_full_set();
        logic [6:0] ord;
        while (set_count > 0) begin
            send_item(OP_DRAW, 3'($urandom_range(7)), 4'($urandom_range(15)), 6'd0);
        end
        while (set_count < CAPACITY) begin
            send_item(OP_INSERT, 3'($urandom_range(7)), 4'($urandom_range(15)),
                      6'($urandom_range(63)));
        end
        send_item(OP_INSERT, set_store[5].suit, set_store[5].rank, 6'd0);
        send_item(OP_INSERT, 3'($urandom_range(7)), 4'($urandom_range(15)), 6'd0);
        send_item(OP_FIND_KEY, set_store[CAPACITY - 1].suit, set_store[CAPACITY - 1].rank,
                  6'd0);
        send_item(OP_SORT, 3'd0, 4'd0, 6'd0);
        send_item(OP_DRAW, 3'd0, 4'd0, 6'd63);
        while (set_count > 0) begin
            send_item(OP_DRAW, 3'd0, 4'd0, 6'($urandom_range(63)));
        end
        for (int o = 127; o >= 64; o--) begin
            ord = 7'(o);
            send_item(OP_INSERT, ord[2:0], ord[6:3], 6'd0);
        end
        send_item(OP_SORT, 3'd0, 4'd0, 6'd0);
        send_item(OP_FIND_RANK, 3'd0, 4'd15, 6'd0);
        while (set_count > 0) begin
            if ($urandom_range(1) == 0) begin
                send_item(OP_REMOVE_RANK, 3'($urandom_range(7)), 4'($urandom_range(15)),
                          6'd0);
            end else begin
                send_item(OP_REMOVE_KEY, set_store[set_count - 1].suit,
                          set_store[set_count - 1].rank, 6'd0);
            end
        end
    endtask

    // Random operations around a target size that wanders between empty and full.
    task automatic test_random_mix(input int items);
        int target_count;
        target_count = 0;
        for (int n = 0; n < items; n++) begin
            if (n % 32 == 0) begin
                target_count = $urandom_range(CAPACITY);
            end
            send_random_item(target_count);
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering beats.
    task automatic test_backpressure();
        int saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_request  = 200;
        for (int n = 0; n < 12; n++) begin
            send_random_item(CAPACITY / 2);
        end
        send_idle_pct = saved_idle;
        wait_drained();
    endtask

    initial begin
        send_idle_pct = 10;
        recv_idle_pct = 83;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed();
        wait_drained();
        test_full_set();
        wait_drained();
        test_random_mix(300);

        send_idle_pct = 83;
        recv_idle_pct = 10;
        test_random_mix(300);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(250);
        test_backpressure();

        if (error_count == 0) begin
            $display("PASS keyed_set_table_engine");
        end else begin
            $display("FAIL keyed_set_table_engine");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/kst_pkg.sv
rtl/core/kst_ram.sv
rtl/core/keyed_set_table_engine.sv
sim/tb_keyed_set_table_engine.sv
